[rtl/hks_pkg.sv]
// shared types, constants and the sha-256 round constant table
package hks_pkg;

  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_WORD0 = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_REGS    = CFG_IDX_W'(8);

  localparam logic [255:0] SHA_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [511:0] IPAD_BLOCK = {64{8'h36}};
  localparam logic [511:0] OPAD_BLOCK = {64{8'h5c}};
  localparam logic [63:0]  INNER_LEN_BITS = 64'd832;
  localparam logic [63:0]  OUTER_LEN_BITS = 64'd768;

  typedef struct packed {
    logic [7:0]  data;
    logic [4:0]  off;
    logic [58:0] blk;
    logic        need;
    logic        last;
  } hks_entry_t;

  typedef enum logic {
    B_IDLE,
    B_HASH
  } hks_back_state_t;

  typedef enum logic [1:0] {
    STEP_INNER_KEY,
    STEP_INNER_MSG,
    STEP_OUTER_KEY,
    STEP_OUTER_MSG
  } hks_step_t;

  function automatic logic [31:0] sha_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

[rtl/hks_if.sv]
// channel interfaces: data in, result out, configuration write
interface hks_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        start_req;
  logic [63:0] start_position;
  logic        last_byte;
  modport source (output valid, data_byte, start_req, start_position, last_byte, input ready);
  modport sink   (input valid, data_byte, start_req, start_position, last_byte, output ready);
endinterface

interface hks_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

interface hks_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

[rtl/hks_sha.sv]
// sha-256 compression unit, one round per cycle
module hks_sha (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [255:0] h_in,
  input  logic [511:0] m_in,
  output logic         done,
  output logic [255:0] digest
);
  import hks_pkg::*;

  logic [7:0][31:0]  wk_r;
  logic [7:0][31:0]  wk_nxt;
  logic [15:0][31:0] w_r;
  logic [15:0][31:0] w_nxt;
  logic [255:0]      hin_r;
  logic [5:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [31:0]       s0, s1, ch, mj, t1, t2, ws0, ws1;

  always_comb begin
    s1  = {wk_r[4][5:0], wk_r[4][31:6]} ^ {wk_r[4][10:0], wk_r[4][31:11]}
        ^ {wk_r[4][24:0], wk_r[4][31:25]};
    ch  = (wk_r[4] & wk_r[5]) ^ (~wk_r[4] & wk_r[6]);
    t1  = wk_r[7] + s1 + ch + sha_k(cnt_r) + w_r[0];
    s0  = {wk_r[0][1:0], wk_r[0][31:2]} ^ {wk_r[0][12:0], wk_r[0][31:13]}
        ^ {wk_r[0][21:0], wk_r[0][31:22]};
    mj  = (wk_r[0] & wk_r[1]) ^ (wk_r[0] & wk_r[2]) ^ (wk_r[1] & wk_r[2]);
    t2  = s0 + mj;
    wk_nxt = {wk_r[6:4], wk_r[3] + t1, wk_r[2:0], t1 + t2};
    ws0 = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    ws1 = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
        ^ (w_r[14] >> 10);
    w_nxt = {w_r[0] + ws0 + w_r[9] + ws1, w_r[15:1]};
    for (int i = 0; i < 8; i++) begin
      digest[255-32*i -: 32] = hin_r[255-32*i -: 32] + wk_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hin_r <= h_in;
      for (int i = 0; i < 8; i++) wk_r[i] <= h_in[255-32*i -: 32];
      for (int i = 0; i < 16; i++) w_r[i] <= m_in[511-32*i -: 32];
    end else if (busy_r) begin
      wk_r <= wk_nxt;
      w_r  <= w_nxt;
    end
  end

  assign done = done_r;

endmodule

[rtl/hks_fifo.sv]
// short queue between front and back
module hks_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hks_pkg::hks_entry_t wdata,
  input  logic                pop,
  output hks_pkg::hks_entry_t rdata,
  output logic                full,
  output logic                empty
);
  import hks_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hks_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= bump(wptr_r);
      if (pop)  rptr_r <= bump(rptr_r);
      if (push && !pop) cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

  assign rdata = mem_r[rptr_r];
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);

endmodule

[rtl/hks_front.sv]
// front end: config registers, position tracking, cache-miss classification
module hks_front (
  input  logic                clk,
  input  logic                rst_n,
  hks_in_if.sink              in_ch,
  hks_cfg_if.sink             cfg_ch,
  input  logic                q_full,
  output logic                q_push,
  output hks_pkg::hks_entry_t q_wdata,
  output logic [255:0]        key,
  output logic [255:0]        nonce
);
  import hks_pkg::*;

  logic [3:0][63:0] key_r, nonce_r;
  logic [63:0]      pos_r;
  logic [58:0]      cidx_r;
  logic             cv_r;
  logic [63:0]      pos;
  logic             cfg_hit;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign q_push       = in_ch.valid && !q_full;
  assign pos          = in_ch.start_req ? in_ch.start_position : pos_r;
  assign cfg_hit      = cfg_ch.valid && (cfg_ch.index < CFG_NUM_REGS);

  always_comb begin
    q_wdata.data = in_ch.data_byte;
    q_wdata.off  = pos[4:0];
    q_wdata.blk  = pos[63:5];
    q_wdata.need = !cv_r || (cidx_r != pos[63:5]);
    q_wdata.last = in_ch.last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      nonce_r <= '0;
      pos_r   <= '0;
      cidx_r  <= '0;
      cv_r    <= 1'b0;
    end else begin
      if (q_push) begin
        pos_r  <= pos + 64'd1;
        cidx_r <= pos[63:5];
        cv_r   <= 1'b1;
      end
      if (cfg_hit) begin
        cv_r <= 1'b0;
        if (cfg_ch.index < CFG_NONCE_WORD0) begin
          key_r[2'd3 - cfg_ch.index[1:0]] <= cfg_ch.wdata;
        end else begin
          nonce_r[2'd3 - cfg_ch.index[1:0]] <= cfg_ch.wdata;
        end
      end
    end
  end

  assign key   = key_r;
  assign nonce = nonce_r;

endmodule

[rtl/hks_back.sv]
// back end: hmac sequencer over the compression unit, keystream xor, output register
module hks_back (
  input  logic                clk,
  input  logic                rst_n,
  input  hks_pkg::hks_entry_t head,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic [255:0]        key,
  input  logic [255:0]        nonce,
  hks_out_if.source           out_ch
);
  import hks_pkg::*;

  hks_back_state_t state_r, state_nxt;
  hks_step_t       step_r, step_nxt;
  logic            hashed_r, hashed_nxt;
  logic [255:0]    idig_r, idig_nxt;
  logic [255:0]    ks_r, ks_nxt;
  logic            ov_r, ov_nxt;
  logic [7:0]      ob_r, ob_nxt;
  logic            ol_r, ol_nxt;
  logic            sha_start, sha_done;
  logic [255:0]    sha_h, sha_digest;
  logic [511:0]    sha_m;
  logic [511:0]    inner_msg, outer_msg;
  logic [63:0]     idx;

  assign idx = {5'b0, head.blk};
  assign inner_msg = {nonce, idx[7:0], idx[15:8], idx[23:16], idx[31:24], idx[39:32],
                      idx[47:40], idx[55:48], idx[63:56], 8'h80, 120'b0, INNER_LEN_BITS};
  assign outer_msg = {idig_r, 8'h80, 184'b0, OUTER_LEN_BITS};

  hks_sha u_sha (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sha_start),
    .h_in   (sha_h),
    .m_in   (sha_m),
    .done   (sha_done),
    .digest (sha_digest)
  );

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    hashed_nxt = hashed_r;
    idig_nxt   = idig_r;
    ks_nxt     = ks_r;
    ov_nxt     = ov_r && !out_ch.ready;
    ob_nxt     = ob_r;
    ol_nxt     = ol_r;
    q_pop      = 1'b0;
    sha_start  = 1'b0;
    sha_h      = SHA_INIT;
    sha_m      = {key, 256'b0} ^ IPAD_BLOCK;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (head.need && !hashed_r) begin
            sha_start = 1'b1;
            step_nxt  = STEP_INNER_KEY;
            state_nxt = B_HASH;
          end else if (!ov_r || out_ch.ready) begin
            q_pop      = 1'b1;
            hashed_nxt = 1'b0;
            ov_nxt     = 1'b1;
            ob_nxt     = head.data ^ ks_r[{~head.off, 3'b111} -: 8];
            ol_nxt     = head.last;
          end
        end
      end
      B_HASH: begin
        if (sha_done) begin
          step_nxt = hks_step_t'(step_r + 2'd1);
          unique case (step_r)
            STEP_INNER_KEY: begin
              sha_start = 1'b1;
              sha_h     = sha_digest;
              sha_m     = inner_msg;
            end
            STEP_INNER_MSG: begin
              idig_nxt  = sha_digest;
              sha_start = 1'b1;
              sha_m     = {key, 256'b0} ^ OPAD_BLOCK;
            end
            STEP_OUTER_KEY: begin
              sha_start = 1'b1;
              sha_h     = sha_digest;
              sha_m     = outer_msg;
            end
            default: begin
              ks_nxt     = sha_digest;
              hashed_nxt = 1'b1;
              state_nxt  = B_IDLE;
            end
          endcase
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      step_r   <= STEP_INNER_KEY;
      hashed_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      hashed_r <= hashed_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idig_r <= idig_nxt;
    ks_r   <= ks_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.out_byte = ob_r;
  assign out_ch.out_last = ol_r;

endmodule

[rtl/hmac_keystream_xor_cipher.sv]
// top level: hmac-sha256 counter-mode keystream xor cipher
//   channel  dir  payload                                           beat when
//   in_ch    in   data_byte, start_req, start_position, last_byte   valid & ready
//   out_ch   out  out_byte, out_last                                valid & ready
//   cfg_ch   in   index, wdata (8 registers, index 0..7)            valid & ready
// a byte within the cached 32-byte keystream block needs no hashing in the back end
// a byte starting a new block waits for four sha-256 compressions in turn on the single
// round unit, then a return to idle
// the queue keeps taking beats while the back end hashes or the output stalls, until it is full
// synchronous active-low reset; no clearing pass, cfg_ch is always ready
module hmac_keystream_xor_cipher #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  hks_in_if.sink    in_ch,
  hks_out_if.source out_ch,
  hks_cfg_if.sink   cfg_ch
);
  import hks_pkg::*;

  hks_entry_t   q_wdata, q_rdata;
  logic         q_push, q_pop, q_full, q_empty;
  logic [255:0] key, nonce;

  hks_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg_ch  (cfg_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .key     (key),
    .nonce   (nonce)
  );

  hks_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  hks_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .key     (key),
    .nonce   (nonce),
    .out_ch  (out_ch)
  );

endmodule

[rtl/hks_checker.sv]
// port-level checks for the cipher top level, bound in
module hks_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("result payload changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cfg_ready)
    else $error("config port not ready");

endmodule

bind hmac_keystream_xor_cipher hks_checker u_hks_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.out_last),
  .cfg_ready (cfg_ch.ready)
);

[tb/sv/hmac_keystream_xor_cipher_tb.sv]
// self-checking testbench for the hmac-sha256 counter-mode keystream xor cipher
module hmac_keystream_xor_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hks_pkg::*;

  typedef struct {
    logic [7:0]  data;
    logic        start;
    logic [63:0] pos;
    logic        last;
  } byte_item_t;

  typedef struct {
    logic [7:0] cipher;
    logic       last;
  } cipher_beat_t;

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [255:0] H0 = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk;
  logic rst_n;

  hks_in_if  in_ch();
  hks_out_if out_ch();
  hks_cfg_if cfg_ch();

  hmac_keystream_xor_cipher uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  byte_item_t   pending_bytes[$];
  cipher_beat_t expected_beats[$];

  logic [63:0]  key_q [0:3];
  logic [63:0]  nonce_q [0:3];
  logic [63:0]  stream_pos;
  logic [255:0] ks_block;
  logic [58:0]  ks_blk_idx;
  logic         ks_valid;

  int  errors;
  int  n_out;
  int  idle_cycles;
  bit  quiet;
  int  send_gap;
  int  recv_stall;
  int  hold_left;
  bit  hold_done;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] compress(logic [255:0] h, logic [511:0] blk);
    logic [31:0] w [0:63];
    logic [31:0] v [0:7];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) w[t] = blk[511 - 32 * t -: 32];
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = h[255 - 32 * i -: 32];
    for (int t = 0; t < 64; t++) begin
      s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
      s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h[255 - 32 * i -: 32] = h[255 - 32 * i -: 32] + v[i];
    return h;
  endfunction

  function automatic logic [255:0] keystream_for(logic [58:0] idx);
    logic [511:0] kpad;
    logic [63:0]  idx_le;
    logic [255:0] inner;
    logic [255:0] h;
    logic [63:0]  blk64;
    blk64 = {5'b0, idx};
    for (int i = 0; i < 8; i++) idx_le[63 - 8 * i -: 8] = blk64[8 * i +: 8];
    kpad = {key_q[0], key_q[1], key_q[2], key_q[3], 256'b0};
    h = compress(H0, kpad ^ {64{8'h36}});
    inner = compress(h, {nonce_q[0], nonce_q[1], nonce_q[2], nonce_q[3], idx_le,
                         8'h80, 120'b0, 64'd832});
    h = compress(H0, kpad ^ {64{8'h5c}});
    return compress(h, {inner, 8'h80, 184'b0, 64'd768});
  endfunction

  function automatic void predict_cipher(byte_item_t it);
    logic [63:0]  p;
    cipher_beat_t e;
    p = it.start ? it.pos : stream_pos;
    if (!ks_valid || ks_blk_idx != p[63:5]) begin
      ks_block = keystream_for(p[63:5]);
      ks_blk_idx = p[63:5];
      ks_valid = 1'b1;
    end
    e.cipher = it.data ^ ks_block[255 - 8 * p[4:0] -: 8];
    e.last = it.last;
    expected_beats.push_back(e);
    stream_pos = p + 64'd1;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    byte_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        it.data = in_ch.data_byte;
        it.start = in_ch.start_req;
        it.pos = in_ch.start_position;
        it.last = in_ch.last_byte;
        predict_cipher(it);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          it = pending_bytes.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.data_byte <= it.data;
          in_ch.start_req <= it.start;
          in_ch.start_position <= it.pos;
          in_ch.last_byte <= it.last;
          if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 15);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall = 0;
      hold_left = 0;
    end else begin
      if (!hold_done && n_out == 150) begin
        hold_left = 800;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_stall = $urandom_range(1, 15);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cipher_beat_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_out++;
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", out_ch.out_byte, 8'h00);
      end else begin
        e = expected_beats.pop_front();
        if (out_ch.out_byte !== e.cipher) report_mismatch("out_byte", out_ch.out_byte, e.cipher);
        if (out_ch.out_last !== e.last)
          report_mismatch("out_last", 8'(out_ch.out_last), 8'(e.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("hmac_keystream_xor_cipher test failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx < CFG_NONCE_WORD0) begin
      key_q[idx - CFG_KEY_WORD0] = value;
      ks_valid = 1'b0;
    end else if (idx < CFG_NUM_REGS) begin
      nonce_q[idx - CFG_NONCE_WORD0] = value;
      ks_valid = 1'b0;
    end
  endtask

  task automatic queue_byte(logic [7:0] d, logic s, logic [63:0] p, logic l);
    byte_item_t it;
    it.data = d;
    it.start = s;
    it.pos = p;
    it.last = l;
    pending_bytes.push_back(it);
  endtask

  function automatic logic [63:0] pick_position();
    case ($urandom_range(0, 4))
      0: return {$urandom, $urandom};
      1: return 64'hffff_ffff_ffff_ffff - $urandom_range(0, 70);
      2: return 64'($urandom_range(0, 100));
      3: return stream_pos + 64'($urandom_range(0, 40));
      default: return {$urandom, $urandom} & ~64'h1f;
    endcase
  endfunction

  task automatic queue_random(int count);
    int n;
    int len;
    logic [63:0] p;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_byte(8'($urandom), 1'($urandom), {$urandom, $urandom}, 1'($urandom));
        n++;
      end else begin
        len = $urandom_range(1, 40);
        p = pick_position();
        for (int i = 0; i < len; i++)
          queue_byte(8'($urandom), i == 0, (i == 0) ? p : {$urandom, $urandom}, i == len - 1);
        n += len;
      end
    end
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_bytes.size() > 0 || in_ch.valid || expected_beats.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_all(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3,
                           logic [63:0] n0, logic [63:0] n1, logic [63:0] n2, logic [63:0] n3);
    write_reg(CFG_KEY_WORD0, k0);
    write_reg(CFG_KEY_WORD0 + CFG_IDX_W'(1), k1);
    write_reg(CFG_KEY_WORD0 + CFG_IDX_W'(2), k2);
    write_reg(CFG_KEY_WORD0 + CFG_IDX_W'(3), k3);
    write_reg(CFG_NONCE_WORD0, n0);
    write_reg(CFG_NONCE_WORD0 + CFG_IDX_W'(1), n1);
    write_reg(CFG_NONCE_WORD0 + CFG_IDX_W'(2), n2);
    write_reg(CFG_NONCE_WORD0 + CFG_IDX_W'(3), n3);
  endtask

  initial begin
    errors = 0;
    n_out = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    hold_done = 1'b0;
    stream_pos = '0;
    ks_block = '0;
    ks_blk_idx = '0;
    ks_valid = 1'b0;
    for (int i = 0; i < 4; i++) begin
      key_q[i] = '0;
      nonce_q[i] = '0;
    end
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.start_req = 1'b0;
    in_ch.start_position = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.wdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset key and nonce, position running from zero
    queue_byte(8'h00, 1'b0, 64'h0, 1'b0);
    queue_byte(8'hff, 1'b0, 64'hffff_ffff_ffff_ffff, 1'b1);
    queue_byte(8'ha5, 1'b0, 64'h0, 1'b0);
    // block boundary
    queue_byte(8'h5a, 1'b1, 64'd30, 1'b0);
    queue_byte(8'h01, 1'b0, 64'h0, 1'b0);
    queue_byte(8'h80, 1'b0, 64'h0, 1'b1);
    queue_byte(8'h7f, 1'b0, 64'h0, 1'b0);
    // restart inside the cached block
    queue_byte(8'h3c, 1'b1, 64'd33, 1'b0);
    // position wrap
    queue_byte(8'hc3, 1'b1, 64'hffff_ffff_ffff_fffe, 1'b0);
    queue_byte(8'hff, 1'b0, 64'h0, 1'b0);
    queue_byte(8'h00, 1'b0, 64'h0, 1'b1);
    queue_byte(8'h11, 1'b1, 64'h8000_0000_0000_0000, 1'b1);
    queue_byte(8'hee, 1'b1, 64'h5555_5555_5555_5555, 1'b0);
    queue_byte(8'h22, 1'b1, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
    queue_byte(8'hdd, 1'b1, 64'h0, 1'b0);
    drain();

    write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    write_reg(CFG_NUM_REGS, {$urandom, $urandom});
    write_reg(CFG_NUM_REGS + CFG_IDX_W'(7), '1);
    queue_byte(8'h96, 1'b0, 64'h0, 1'b0);
    queue_random(450);
    drain();

    write_all('1, '1, '1, '1, '1, '1, '1, '1);
    queue_random(300);
    drain();

    write_all('0, '0, '0, '0, '0, '0, '0, '0);
    write_reg(CFG_KEY_WORD0 + CFG_IDX_W'(2), {$urandom, $urandom});
    write_reg(CFG_NONCE_WORD0 + CFG_IDX_W'(1), {$urandom, $urandom});
    queue_random(150);
    drain();
    quiet = 1'b1;
    queue_random(330);
    drain();

    repeat (300) @(posedge clk);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("hmac_keystream_xor_cipher test passed");
    end else begin
      $display("hmac_keystream_xor_cipher test failed");
    end
    $finish;
  end
endmodule

[files.f]
rtl/hks_pkg.sv
rtl/hks_if.sv
rtl/hks_sha.sv
rtl/hks_fifo.sv
rtl/hks_front.sv
rtl/hks_back.sv
rtl/hmac_keystream_xor_cipher.sv
rtl/hks_checker.sv
tb/sv/hmac_keystream_xor_cipher_tb.sv
